// ----- design/zcem_pkg.sv -----
// Package: shared types, constants and helpers for the zero-crossing edge magnitude block.
`timescale 1ns / 1ps

package zcem_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_WIDTH   = 2048;
  localparam int COL_BITS    = 11;
  localparam int ROW_BITS    = 12;
  localparam int CFG_BITS    = 12;
  localparam int MAG_OUT_BITS = 16;
  localparam int SUM_BITS    = SAMPLE_BITS + 2;
  localparam int ABS_BITS    = SUM_BITS - 1;
  localparam int PROD_BITS   = 2 * ABS_BITS;
  localparam int RECIP_SHIFT = 18;
  localparam int LINE_BITS   = 2 * SAMPLE_BITS;
  localparam int PADDR_BITS  = 3;
  localparam int PDATA_BITS  = 32;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_PTR_BITS = 3;
  localparam int FIFO_CNT_BITS = 4;
  localparam int CREDIT_BITS = 5;

  // ceil(2^18 / 3): exact truncating divide by three for magnitudes below 2^17
  localparam logic [ABS_BITS-1:0] RECIP3 = 17'd87382;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [CFG_BITS-1:0] MIN_DIM      = 12'd3;
  localparam logic [CFG_BITS-1:0] MAX_COLS     = 12'd2048;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t error_sample;
    logic    frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [MAG_OUT_BITS-1:0] horizontal_mag;
    logic [MAG_OUT_BITS-1:0] vertical_mag;
    logic [MAG_OUT_BITS-1:0] edge_mag;
    logic [ROW_BITS-1:0]     center_row;
    logic [COL_BITS-1:0]     center_col;
    logic                    frame_last;
  } out_beat_t;

  typedef struct packed {
    logic                emit;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                last;
  } tag_t;

  typedef struct packed {
    logic    valid;
    sample_t above;
    sample_t centre;
    sample_t sample;
    tag_t    tag;
  } win_col_t;

  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } result_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } flt_status_t;

  function automatic logic signed [SUM_BITS-1:0] sum3(sample_t a, sample_t b, sample_t c);
    return SUM_BITS'(a) + SUM_BITS'(b) + SUM_BITS'(c);
  endfunction

endpackage

// ----- design/zcem_filter.sv -----
// 3x3 window, averages of three and zero-crossing magnitudes.
`timescale 1ns / 1ps

module zcem_filter
  import zcem_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  win_col_t    col_i,
  output result_t     res_o,
  output flt_status_t status_o
);

  sample_t win_r [3][3];

  logic v2_r, v3_r, v4_r;
  tag_t tag2_r, tag3_r, tag4_r;

  logic [ABS_BITS-1:0]     abs3_r [4];
  logic                    neg3_r [4];
  logic [MAG_OUT_BITS-1:0] q4_r   [4];
  logic                    neg4_r [4];

  logic signed [SUM_BITS-1:0] sum_w [4];
  logic [PROD_BITS-1:0]       prod_w [4];
  logic                       pos_w [4];
  logic                       ngt_w [4];
  logic [MAG_OUT_BITS-1:0]    hm_w, vm_w, em_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (col_i.valid) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= col_i.above;
      win_r[1][2] <= col_i.centre;
      win_r[2][2] <= col_i.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v2_r <= col_i.valid && col_i.tag.emit;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // right, left, below, above
  always_comb begin
    sum_w[0] = sum3(win_r[0][2], win_r[1][2], win_r[2][2]);
    sum_w[1] = sum3(win_r[0][0], win_r[1][0], win_r[2][0]);
    sum_w[2] = sum3(win_r[2][0], win_r[2][1], win_r[2][2]);
    sum_w[3] = sum3(win_r[0][0], win_r[0][1], win_r[0][2]);
  end

  always_ff @(posedge clk) begin
    tag2_r <= col_i.tag;
    tag3_r <= tag2_r;
    tag4_r <= tag3_r;
    for (int k = 0; k < 4; k++) begin
      neg3_r[k] <= sum_w[k][SUM_BITS-1];
      abs3_r[k] <= sum_w[k][SUM_BITS-1] ? ABS_BITS'(-sum_w[k]) : ABS_BITS'(sum_w[k]);
      neg4_r[k] <= neg3_r[k];
      q4_r[k]   <= prod_w[k][RECIP_SHIFT +: MAG_OUT_BITS];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod_w[k] = PROD_BITS'(abs3_r[k]) * PROD_BITS'(RECIP3);
      pos_w[k]  = !neg4_r[k] && (q4_r[k] != '0);
      ngt_w[k]  = neg4_r[k] && (q4_r[k] != '0);
    end
    if ((pos_w[0] && ngt_w[1]) || (ngt_w[0] && pos_w[1])) begin
      hm_w = (q4_r[0] > q4_r[1]) ? q4_r[0] : q4_r[1];
    end else begin
      hm_w = '0;
    end
    if ((pos_w[2] && ngt_w[3]) || (ngt_w[2] && pos_w[3])) begin
      vm_w = (q4_r[2] > q4_r[3]) ? q4_r[2] : q4_r[3];
    end else begin
      vm_w = '0;
    end
    em_w = (hm_w > vm_w) ? hm_w : vm_w;
  end

  assign res_o.valid               = v4_r;
  assign res_o.beat.horizontal_mag = hm_w;
  assign res_o.beat.vertical_mag   = vm_w;
  assign res_o.beat.edge_mag       = em_w;
  assign res_o.beat.center_row     = tag4_r.row;
  assign res_o.beat.center_col     = tag4_r.col;
  assign res_o.beat.frame_last     = tag4_r.last;

  assign status_o.s2 = v2_r;
  assign status_o.s3 = v3_r;
  assign status_o.s4 = v4_r;

endmodule

// ----- design/zero_crossing_edge_magnitude.sv -----
// Top level: raster counters, line memory, result queue and register port.
`timescale 1ns / 1ps

// Usage notes
// Input channel (in_valid/in_stall/in_data) takes one Q9.7 error sample per beat in
// raster order; frame_start on a beat restarts the row and column counters.
// Output channel (out_valid/out_stall/out_data) gives one result beat per interior
// pixel, tagged with the centre row/column and frame_last; border pixels give none.
// A sample passes the input, window, absolute-value and quotient registers and the
// result queue before its result shows on out_valid. Throughput: one sample per clock
// while in_stall is low. Each column of the line memory is read once and written back
// once per sample; back-to-back hits on one column are forwarded. Results sit in an
// 8-deep queue. in_stall rises when queued plus in-flight results could fill it, so a
// stalled receiver halts the input after at most a few beats and nothing is dropped.
// Reset (rst_n, synchronous): counters to zero, image_width 640, image_height 480,
// queue empty. The line memory is not cleared; rows 0 and 1 of each frame refill it
// before any result depends on it.
// Registers: image_width at 0x0, image_height at 0x4; write only while idle.

module zero_crossing_edge_magnitude
  import zcem_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);

  logic [CFG_BITS-1:0] width_r, height_r;
  logic [CFG_BITS-1:0] w_eff, h_eff;
  logic                cfg_wr;

  logic [COL_BITS-1:0] col_r, col_nxt;
  logic [ROW_BITS-1:0] row_r, row_nxt;
  logic [CFG_BITS-1:0] col_cur, col_inc;
  logic [ROW_BITS-1:0] row_cur, row_step;
  logic                accept;
  tag_t                tag_w;

  logic [LINE_BITS-1:0] lmem [MAX_WIDTH];
  logic [LINE_BITS-1:0] rd_q_r, fwd_data_r, line_w, wr_data;
  logic                 fwd_r;
  logic                 v1_r;
  sample_t              s1_sample_r;
  logic [COL_BITS-1:0]  s1_col_r;
  tag_t                 s1_tag_r;

  win_col_t    win_col;
  result_t     res;
  flt_status_t flt_st;

  out_beat_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_BITS-1:0] fifo_cnt_r;
  logic                     fifo_push, fifo_pop;
  logic [CREDIT_BITS-1:0]   credit_w;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_IMAGE_WIDTH:  width_r  <= pwdata[CFG_BITS-1:0];
        REG_IMAGE_HEIGHT: height_r <= pwdata[CFG_BITS-1:0];
        default:          width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_IMAGE_WIDTH:  prdata = PDATA_BITS'(width_r);
      REG_IMAGE_HEIGHT: prdata = PDATA_BITS'(height_r);
      default:          prdata = '0;
    endcase
  end

  assign w_eff = (width_r < MIN_DIM) ? MIN_DIM : ((width_r > MAX_COLS) ? MAX_COLS : width_r);
  assign h_eff = (height_r < MIN_DIM) ? MIN_DIM : height_r;

  // raster position of the incoming beat and the position after it
  assign accept = in_valid && !in_stall;

  always_comb begin
    col_cur = in_data.frame_start ? '0 : CFG_BITS'(col_r);
    row_cur = in_data.frame_start ? '0 : row_r;
    if (col_cur >= w_eff) begin
      col_cur = '0;
      row_cur = row_cur + 1'b1;
    end
    if (row_cur >= h_eff) begin
      row_cur = '0;
    end
    col_inc  = col_cur + 1'b1;
    row_step = row_cur + 1'b1;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_step >= h_eff) ? '0 : row_step;
    end else begin
      col_nxt = col_inc[COL_BITS-1:0];
      row_nxt = row_cur;
    end
    tag_w.emit = (row_cur >= ROW_BITS'(2)) && (col_cur >= CFG_BITS'(2));
    tag_w.row  = row_cur - 1'b1;
    tag_w.col  = col_cur[COL_BITS-1:0] - 1'b1;
    tag_w.last = (row_cur == h_eff - 1'b1) && (col_cur == w_eff - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line memory: entry holds {two rows up, one row up} for one column
  assign line_w  = fwd_r ? fwd_data_r : rd_q_r;
  assign wr_data = {line_w[SAMPLE_BITS-1:0], s1_sample_r};

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q_r <= lmem[col_cur[COL_BITS-1:0]];
    end
    if (v1_r) begin
      lmem[s1_col_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      v1_r  <= accept;
      fwd_r <= v1_r && (s1_col_r == col_cur[COL_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= wr_data;
    if (accept) begin
      s1_sample_r <= in_data.error_sample;
      s1_col_r    <= col_cur[COL_BITS-1:0];
      s1_tag_r    <= tag_w;
    end
  end

  assign win_col.valid  = v1_r;
  assign win_col.above  = sample_t'(line_w[LINE_BITS-1:SAMPLE_BITS]);
  assign win_col.centre = sample_t'(line_w[SAMPLE_BITS-1:0]);
  assign win_col.sample = s1_sample_r;
  assign win_col.tag    = s1_tag_r;

  zcem_filter u_filter (
    .clk      (clk),
    .rst_n    (rst_n),
    .col_i    (win_col),
    .res_o    (res),
    .status_o (flt_st)
  );

  // result queue
  assign fifo_push = res.valid;
  assign fifo_pop  = out_valid && !out_stall;
  assign out_valid = (fifo_cnt_r != '0);
  assign out_data  = fifo_r[rd_ptr_r];

  assign credit_w = CREDIT_BITS'(fifo_cnt_r) + CREDIT_BITS'(v1_r) + CREDIT_BITS'(flt_st.s2)
                  + CREDIT_BITS'(flt_st.s3) + CREDIT_BITS'(flt_st.s4);
  assign in_stall = (credit_w >= CREDIT_BITS'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      fifo_r[wr_ptr_r] <= res.beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (fifo_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (fifo_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (fifo_push && !fifo_pop) begin
        fifo_cnt_r <= fifo_cnt_r + 1'b1;
      end else if (fifo_pop && !fifo_push) begin
        fifo_cnt_r <= fifo_cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> (fifo_cnt_r != FIFO_CNT_BITS'(FIFO_DEPTH)) || fifo_pop)
    else $error("result queue overflow");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !cfg_wr |=> (CFG_BITS'(col_r) < w_eff))
    else $error("column counter beyond width");

  a_edge_is_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.edge_mag >= out_data.horizontal_mag)
               && (out_data.edge_mag >= out_data.vertical_mag)
               && ((out_data.edge_mag == out_data.horizontal_mag)
                   || (out_data.edge_mag == out_data.vertical_mag)))
    else $error("edge magnitude is not the larger of the pair");

  a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.center_row != '0) && (out_data.center_col != '0))
    else $error("border pixel emitted");
`endif

endmodule

// ----- tb/tb_zero_crossing_edge_magnitude.sv -----
// Testbench for the zero-crossing edge magnitude block: directed frames, random frames, APB sizes.
`timescale 1ns / 1ps

module tb_zero_crossing_edge_magnitude;
  import zcem_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int DIR_ROWS    = 29;
  localparam int SMALL_ITEMS = 1200;
  localparam int DRAIN_WAIT  = 8;

  localparam sample_t S_MIN = 16'sh8000;
  localparam sample_t S_MAX = 16'sh7FFF;
  localparam sample_t S_ZERO = 16'sh0000;
  localparam out_beat_t FULL_H = '{16'h8000, 16'h0000, 16'h8000, 12'd1, 11'd1, 1'b1};
  localparam out_beat_t FULL_V = '{16'h0000, 16'h8000, 16'h8000, 12'd1, 11'd1, 1'b1};

  typedef struct packed {
    sample_t   smp;
    logic      fs;
    logic      typed;
    out_beat_t want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_beat_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_beat_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  zero_crossing_edge_magnitude dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [CFG_BITS-1:0] width_reg;
  logic [CFG_BITS-1:0] height_reg;
  int line_up [MAX_WIDTH];
  int line_mid [MAX_WIDTH];
  int win [3][3];
  int row_cnt;
  int col_cnt;

  out_beat_t pending_mags[$];
  int mismatches;
  int fed_items;
  int cycle_count;
  int stall_pct;
  int stall_left;

  dir_row_t directed_rows [DIR_ROWS] = '{
    // horizontal crossing at full scale
    '{S_MIN, 1'b1, 1'b0, '0}, '{S_ZERO, 1'b0, 1'b0, '0}, '{S_MAX, 1'b0, 1'b0, '0},
    '{S_MIN, 1'b0, 1'b0, '0}, '{S_ZERO, 1'b0, 1'b0, '0}, '{S_MAX, 1'b0, 1'b0, '0},
    '{S_MIN, 1'b0, 1'b0, '0}, '{S_ZERO, 1'b0, 1'b0, '0}, '{S_MAX, 1'b0, 1'b1, FULL_H},
    // frame wraps on its own; vertical crossing, zero column averages
    '{S_MAX, 1'b0, 1'b0, '0}, '{S_MAX, 1'b0, 1'b0, '0}, '{S_MAX, 1'b0, 1'b0, '0},
    '{S_ZERO, 1'b0, 1'b0, '0}, '{S_ZERO, 1'b0, 1'b0, '0}, '{S_ZERO, 1'b0, 1'b0, '0},
    '{S_MIN, 1'b0, 1'b0, '0}, '{S_MIN, 1'b0, 1'b0, '0}, '{S_MIN, 1'b0, 1'b1, FULL_V},
    // stray beats, restart mid-frame, small values that truncate toward zero
    '{16'sh1234, 1'b0, 1'b0, '0}, '{16'shFFFB, 1'b0, 1'b0, '0},
    '{16'shFFFC, 1'b1, 1'b0, '0}, '{16'sh0007, 1'b0, 1'b0, '0}, '{16'sh0002, 1'b0, 1'b0, '0},
    '{16'shFFFF, 1'b0, 1'b0, '0}, '{16'shFED4, 1'b0, 1'b0, '0}, '{16'sh0002, 1'b0, 1'b0, '0},
    '{S_ZERO, 1'b0, 1'b0, '0}, '{16'sh0005, 1'b0, 1'b0, '0}, '{16'sh0001, 1'b0, 1'b0, '0}
  };

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int used_width(logic [CFG_BITS-1:0] v);
    if (v < 3) return 3;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return int'(v);
  endfunction

  function automatic int used_height(logic [CFG_BITS-1:0] v);
    return (v < 3) ? 3 : int'(v);
  endfunction

  function automatic int avg3(int a, int b, int c);
    return (a + b + c) / 3;
  endfunction

  function automatic int crossing_mag(int a, int b);
    int x;
    int y;
    if (!((a > 0 && b < 0) || (a < 0 && b > 0))) return 0;
    x = (a < 0) ? -a : a;
    y = (b < 0) ? -b : b;
    return (x > y) ? x : y;
  endfunction

  function automatic bit predict_edge_mags(in_beat_t b, output out_beat_t r);
    sample_t smp;
    int s;
    int w;
    int h;
    int rw;
    int c;
    int above;
    int centre;
    int hm;
    int vm;
    int em;
    int i;
    bit emitted;
    smp = b.error_sample;
    s = smp;
    w = used_width(width_reg);
    h = used_height(height_reg);
    r = '0;
    if (b.frame_start) begin
      row_cnt = 0;
      col_cnt = 0;
    end
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    rw = row_cnt;
    c = col_cnt;
    above = line_up[c];
    centre = line_mid[c];
    line_up[c] = centre;
    line_mid[c] = s;
    for (i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = above;
    win[1][2] = centre;
    win[2][2] = s;
    emitted = (rw >= 2 && c >= 2);
    if (emitted) begin
      hm = crossing_mag(avg3(win[0][2], win[1][2], win[2][2]),
                        avg3(win[0][0], win[1][0], win[2][0]));
      vm = crossing_mag(avg3(win[2][0], win[2][1], win[2][2]),
                        avg3(win[0][0], win[0][1], win[0][2]));
      em = (hm > vm) ? hm : vm;
      r.horizontal_mag = hm[15:0];
      r.vertical_mag   = vm[15:0];
      r.edge_mag       = em[15:0];
      r.center_row     = ROW_BITS'(rw - 1);
      r.center_col     = COL_BITS'(c - 1);
      r.frame_last     = (rw == h - 1 && c == w - 1);
    end
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= h) row_cnt = 0;
    end
    return emitted;
  endfunction

  function automatic sample_t rand_error();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? S_MAX : S_MIN;
      1: return sample_t'($urandom_range(0, 8) - 4);
      2: return sample_t'($urandom_range(0, 2000) - 1000);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("ERROR %0t: %s", $time, msg);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [CFG_BITS-1:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {20'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    @(posedge clk);
  endtask

  task automatic push_sample(in_beat_t b, int gap_pct);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_data <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fed_items++;
  endtask

  task automatic feed(in_beat_t b, int gap_pct);
    out_beat_t r;
    if (fed_items % 500 == 250 && fed_items < SMALL_ITEMS) begin
      // hold off until the result queue is empty
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending_mags.size() != 0) @(posedge clk);
    end
    push_sample(b, gap_pct);
    if (predict_edge_mags(b, r)) pending_mags.push_back(r);
  endtask

  task automatic run_phase(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h, int n,
                           int gap_pct, bit noisy, bit fresh);
    bit restart;
    in_beat_t b;
    int i;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_mags.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    // a wider row would read line memory not yet filled this frame
    restart = fresh || (used_width(w) > used_width(width_reg));
    apb_write(REG_IMAGE_WIDTH, w);
    apb_write(REG_IMAGE_HEIGHT, h);
    for (i = 0; i < n; i++) begin
      b.error_sample = rand_error();
      b.frame_start = (i == 0 && restart) || (noisy && $urandom_range(0, 99) == 0);
      feed(b, gap_pct);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_mags.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %p", out_data));
      end else begin
        want = pending_mags.pop_front();
        if (out_data.horizontal_mag !== want.horizontal_mag)
          report_mismatch($sformatf("horizontal_mag %0d, want %0d",
                                    out_data.horizontal_mag, want.horizontal_mag));
        if (out_data.vertical_mag !== want.vertical_mag)
          report_mismatch($sformatf("vertical_mag %0d, want %0d",
                                    out_data.vertical_mag, want.vertical_mag));
        if (out_data.edge_mag !== want.edge_mag)
          report_mismatch($sformatf("edge_mag %0d, want %0d",
                                    out_data.edge_mag, want.edge_mag));
        if (out_data.center_row !== want.center_row)
          report_mismatch($sformatf("center_row %0d, want %0d",
                                    out_data.center_row, want.center_row));
        if (out_data.center_col !== want.center_col)
          report_mismatch($sformatf("center_col %0d, want %0d",
                                    out_data.center_col, want.center_col));
        if (out_data.frame_last !== want.frame_last)
          report_mismatch($sformatf("frame_last %0b, want %0b",
                                    out_data.frame_last, want.frame_last));
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
        stall_left = $urandom_range(1, 5);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int k;
    int gap;
    in_beat_t b;
    out_beat_t r;
    bit emitted;
    int fixed_w [5] = '{5, 0, 17, 10, 4};
    int fixed_h [5] = '{4, 2, 9, 8, 3};
    int fixed_n [5] = '{200, 150, 400, 37, 120};

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    fed_items = 0;
    cycle_count = 0;
    stall_left = 0;
    stall_pct = 20;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    row_cnt = 0;
    col_cnt = 0;
    for (k = 0; k < MAX_WIDTH; k++) begin
      line_up[k] = 0;
      line_mid[k] = 0;
    end
    for (k = 0; k < 9; k++) win[k / 3][k % 3] = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    apb_write(REG_IMAGE_WIDTH, 12'd3);
    apb_write(REG_IMAGE_HEIGHT, 12'd3);
    for (k = 0; k < DIR_ROWS; k++) begin
      b.error_sample = directed_rows[k].smp;
      b.frame_start = directed_rows[k].fs;
      push_sample(b, 20);
      emitted = predict_edge_mags(b, r);
      if (directed_rows[k].typed) pending_mags.push_back(directed_rows[k].want);
      else if (emitted) pending_mags.push_back(r);
    end

    // the 10x8 run is short, so the 4x3 run may start beyond the new sizes
    for (k = 0; k < 5; k++) begin
      stall_pct = 10 * k;
      run_phase(CFG_BITS'(fixed_w[k]), CFG_BITS'(fixed_h[k]), fixed_n[k], 25 - 5 * k,
                (k == 0 || k == 2), 1'b0);
    end

    while (fed_items < SMALL_ITEMS) begin
      stall_pct = $urandom_range(0, 3) * 10;
      gap = $urandom_range(0, 3) * 10;
      run_phase(($urandom_range(0, 7) == 0) ? CFG_BITS'($urandom_range(0, 2))
                                            : CFG_BITS'($urandom_range(3, 24)),
                ($urandom_range(0, 7) == 0) ? CFG_BITS'($urandom_range(0, 2))
                                            : CFG_BITS'($urandom_range(3, 12)),
                $urandom_range(60, 300), gap, 1'b1, 1'b0);
    end

    // clamped width and the largest height
    stall_pct = 5;
    run_phase(12'd4095, 12'd3, 250, 5, 1'b0, 1'b1);
    run_phase(12'd0, 12'd4095, 150, 5, 1'b0, 1'b1);

    stall_pct = 0;
    run_phase(12'd6, 12'd5, 200, 0, 1'b0, 1'b0);

    in_valid <= 1'b0;
    while (pending_mags.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/zcem_pkg.sv
design/zcem_filter.sv
design/zero_crossing_edge_magnitude.sv
tb/tb_zero_crossing_edge_magnitude.sv
